// ===== hw/rtl/ttf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_pkg
// shared widths, constants and the triangle job record for the tangent frame core
// ----------------------------------------------------------------------------
package ttf_pkg;

    localparam int POS_W    = 32;
    localparam int TEX_W    = 24;
    localparam int EDGE_W   = POS_W + 1;
    localparam int UV_W     = TEX_W + 1;
    localparam int IN_W     = 3 * POS_W + 2 * TEX_W;
    localparam int AX_W     = 32;
    localparam int NRM_W    = 16;
    localparam int OUT_W    = 6 * AX_W + 3 * NRM_W;
    localparam int SQ_IN_W  = 62;
    localparam int LEN_W    = 31;
    localparam int NUM_W    = 61;
    localparam int QUO_W    = 32;
    localparam int NRM_FRAC = 14;
    localparam int TAN_FRAC = 30;

    localparam int TTF_QUEUE_DEPTH = 2;

    localparam logic [AX_W-1:0] AXIS_ONE = 32'h0001_0000;

    typedef struct packed {
        logic signed [EDGE_W-1:0] e1x;
        logic signed [EDGE_W-1:0] e1y;
        logic signed [EDGE_W-1:0] e1z;
        logic signed [EDGE_W-1:0] e2x;
        logic signed [EDGE_W-1:0] e2y;
        logic signed [EDGE_W-1:0] e2z;
        logic signed [UV_W-1:0]   t1;
        logic signed [UV_W-1:0]   b1;
        logic signed [UV_W-1:0]   t2;
        logic signed [UV_W-1:0]   b2;
    } t_job;

endpackage

// ===== hw/rtl/ttf_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_isqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module ttf_isqrt
    import ttf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SQ_IN_W-1:0] i_x,
    output logic               o_done,
    output logic [LEN_W-1:0]   o_root
);

    logic               r_busy;
    logic               r_done;
    logic [SQ_IN_W-1:0] r_x;
    logic [SQ_IN_W-1:0] r_r;
    logic [SQ_IN_W-1:0] r_bit;
    logic [SQ_IN_W-1:0] w_try;

    assign w_try = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == SQ_IN_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_r   <= '0;
            r_bit <= SQ_IN_W'(1) << (SQ_IN_W - 2);
        end else if (r_busy) begin
            if (r_x >= w_try) begin
                r_x <= r_x - w_try;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[LEN_W-1:0];

endmodule

// ===== hw/rtl/ttf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ttf_div
    import ttf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [LEN_W-1:0] i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [LEN_W-1:0] r_rem;
    logic [LEN_W-1:0] r_den;
    logic [LEN_W:0]   w_try;
    logic             w_ge;

    assign w_try = {r_rem, r_num[NUM_W-1]};
    assign w_ge  = w_try >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? LEN_W'(w_try - {1'b0, r_den}) : w_try[LEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num[QUO_W-1:0];

endmodule

// ===== hw/rtl/ttf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_front
// vertex intake: holds the first two vertices and forms edge and uv deltas
// ----------------------------------------------------------------------------
module ttf_front
    import ttf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [IN_W-1:0] i_data,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output t_job            o_job
);

    logic [1:0]              r_phase;
    logic signed [POS_W-1:0] r_hp [6];
    logic signed [TEX_W-1:0] r_ht [4];
    logic signed [POS_W-1:0] w_px, w_py, w_pz;
    logic signed [TEX_W-1:0] w_tu, w_tv;
    logic                    w_third;

    assign w_px    = i_data[POS_W-1:0];
    assign w_py    = i_data[2*POS_W-1:POS_W];
    assign w_pz    = i_data[3*POS_W-1:2*POS_W];
    assign w_tu    = i_data[3*POS_W+TEX_W-1:3*POS_W];
    assign w_tv    = i_data[IN_W-1:3*POS_W+TEX_W];
    assign w_third = r_phase[1];

    assign o_ready     = !w_third || i_job_ready;
    assign o_job_valid = i_valid && w_third;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_valid && o_ready) begin
            r_phase <= w_third ? 2'd0 : r_phase + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !w_third) begin
            if (r_phase[0]) begin
                r_hp[3] <= w_px;
                r_hp[4] <= w_py;
                r_hp[5] <= w_pz;
                r_ht[2] <= w_tu;
                r_ht[3] <= w_tv;
            end else begin
                r_hp[0] <= w_px;
                r_hp[1] <= w_py;
                r_hp[2] <= w_pz;
                r_ht[0] <= w_tu;
                r_ht[1] <= w_tv;
            end
        end
    end

    always_comb begin
        o_job.e1x = EDGE_W'(r_hp[3]) - EDGE_W'(r_hp[0]);
        o_job.e1y = EDGE_W'(r_hp[4]) - EDGE_W'(r_hp[1]);
        o_job.e1z = EDGE_W'(r_hp[5]) - EDGE_W'(r_hp[2]);
        o_job.e2x = EDGE_W'(w_px) - EDGE_W'(r_hp[0]);
        o_job.e2y = EDGE_W'(w_py) - EDGE_W'(r_hp[1]);
        o_job.e2z = EDGE_W'(w_pz) - EDGE_W'(r_hp[2]);
        o_job.t1  = UV_W'(r_ht[2]) - UV_W'(r_ht[0]);
        o_job.b1  = UV_W'(r_ht[3]) - UV_W'(r_ht[1]);
        o_job.t2  = UV_W'(w_tu) - UV_W'(r_ht[0]);
        o_job.b2  = UV_W'(w_tv) - UV_W'(r_ht[1]);
    end

endmodule

// ===== hw/rtl/ttf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_queue
// short job queue between vertex intake and the frame datapath
// ----------------------------------------------------------------------------
module ttf_queue
    import ttf_pkg::*;
#(
    parameter int DEPTH = TTF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_job i_push_job,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_job o_pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = r_cnt != CNT_W'(DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_job    = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && !w_pop |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count did not grow on push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == CNT_W'(DEPTH)) |-> r_wr == r_rd)
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== hw/rtl/ttf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttf_back
// frame datapath: shared multiplier, square root and divider under a sequencer
// ----------------------------------------------------------------------------
module ttf_back
    import ttf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  t_job             i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_data,
    output logic             o_deg
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DET   = 4'd1;
    localparam logic [3:0] S_NSH   = 4'd2;
    localparam logic [3:0] S_CROSS = 4'd3;
    localparam logic [3:0] S_ULD   = 4'd4;
    localparam logic [3:0] S_USH   = 4'd5;
    localparam logic [3:0] S_USQ   = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_UEND  = 4'd9;
    localparam logic [3:0] S_TB    = 4'd10;
    localparam logic [3:0] S_SCL   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    localparam logic [1:0] W_NRM = 2'd0;
    localparam logic [1:0] W_TAN = 2'd1;
    localparam logic [1:0] W_BIT = 2'd2;

    localparam int MW    = 34;
    localparam int ACC_W = 64;
    localparam int VEC_W = 62;
    localparam int MAG_W = 61;
    localparam int DET_W = 51;
    localparam int DM_W  = DET_W - 1;
    localparam int LO_W  = 23;

    logic [3:0]               r_state;
    logic [1:0]               r_i;
    logic [1:0]               r_k;
    logic [1:0]               r_which;
    logic signed [EDGE_W-1:0] r_e1 [3];
    logic signed [EDGE_W-1:0] r_e2 [3];
    logic signed [UV_W-1:0]   r_t1, r_b1, r_t2, r_b2;
    logic signed [DET_W-1:0]  r_det;
    logic [POS_W-1:0]         r_na [3];
    logic [POS_W-1:0]         r_nb [3];
    logic signed [VEC_W-1:0]  r_vec [3];
    logic [MAG_W-1:0]         r_mag [3];
    logic [LEN_W-1:0]         r_len;
    logic signed [QUO_W-1:0]  r_unit [3];
    logic [NRM_W-1:0]         r_nrm [3];
    logic [AX_W-1:0]          r_tan [3];
    logic [AX_W-1:0]          r_bit [3];
    logic                     r_deg;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_prod;
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_out_data;
    logic                     r_out_deg;

    logic signed [MW-1:0]     m_a, m_b;
    logic signed [2*MW-1:0]   w_mul;
    logic signed [ACC_W-1:0]  w_diff;
    logic [1:0]               w_j, w_l;
    logic                     w_last_i;
    logic                     w_nsh_big;
    logic                     w_ush_big;
    logic                     sq_start, sq_done;
    logic [LEN_W-1:0]         sq_root;
    logic                     dv_start, dv_done;
    logic [QUO_W-1:0]         dv_quo;
    logic [NUM_W-1:0]         w_num;
    logic [MAG_W-1:0]         w_numa;
    logic [DM_W-1:0]          w_dmag;
    logic [QUO_W-2:0]         w_umag;
    logic signed [ACC_W-1:0]  w_rnd;
    logic [34:0]              w_sm;
    logic                     w_neg;
    logic [AX_W-1:0]          w_sat;
    logic                     w_out_load;

    function automatic logic signed [MW-1:0] shv(input logic signed [EDGE_W-1:0] e,
                                                 input logic [POS_W-1:0] m);
        logic signed [MW-1:0] p;
        p = $signed({2'b00, m});
        return e[EDGE_W-1] ? -p : p;
    endfunction

    function automatic logic [MAG_W-1:0] vmag(input logic signed [VEC_W-1:0] v);
        logic signed [VEC_W-1:0] n;
        n = -v;
        return v[VEC_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] emag(input logic signed [EDGE_W-1:0] e);
        logic signed [EDGE_W-1:0] n;
        n = -e;
        return e[EDGE_W-1] ? n[POS_W-1:0] : e[POS_W-1:0];
    endfunction

    assign w_j      = (r_i == 2'd2) ? 2'd0 : r_i + 2'd1;
    assign w_l      = (r_i == 2'd0) ? 2'd2 : r_i - 2'd1;
    assign w_last_i = r_i == 2'd2;
    assign w_diff   = r_acc - r_prod;

    assign w_nsh_big = (|r_na[0][POS_W-1:30]) || (|r_na[1][POS_W-1:30]) ||
                       (|r_na[2][POS_W-1:30]) || (|r_nb[0][POS_W-1:30]) ||
                       (|r_nb[1][POS_W-1:30]) || (|r_nb[2][POS_W-1:30]);
    assign w_ush_big = (|r_mag[0][MAG_W-1:30]) || (|r_mag[1][MAG_W-1:30]) ||
                       (|r_mag[2][MAG_W-1:30]);

    assign w_dmag = r_det[DET_W-1] ? DM_W'(-r_det) : r_det[DM_W-1:0];
    assign w_umag = r_unit[r_i][QUO_W-1] ? (QUO_W-1)'(-r_unit[r_i])
                                         : r_unit[r_i][QUO_W-2:0];

    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_DET: begin
                if (r_k == 2'd0) begin
                    m_a = MW'(r_t1);
                    m_b = MW'(r_b2);
                end else begin
                    m_a = MW'(r_b1);
                    m_b = MW'(r_t2);
                end
            end
            S_CROSS: begin
                if (r_k == 2'd0) begin
                    m_a = shv(r_e1[w_j], r_na[w_j]);
                    m_b = shv(r_e2[w_l], r_nb[w_l]);
                end else begin
                    m_a = shv(r_e1[w_l], r_na[w_l]);
                    m_b = shv(r_e2[w_j], r_nb[w_j]);
                end
            end
            S_TB: begin
                if (r_which == W_TAN) begin
                    m_a = (r_k == 2'd0) ? MW'(r_b2) : MW'(r_b1);
                    m_b = (r_k == 2'd0) ? MW'(r_e1[r_i]) : MW'(r_e2[r_i]);
                end else begin
                    m_a = (r_k == 2'd0) ? MW'(r_t1) : MW'(r_t2);
                    m_b = (r_k == 2'd0) ? MW'(r_e2[r_i]) : MW'(r_e1[r_i]);
                end
            end
            S_USQ: begin
                m_a = $signed(MW'(r_mag[r_i][29:0]));
                m_b = $signed(MW'(r_mag[r_i][29:0]));
            end
            S_SCL: begin
                m_a = (r_k == 2'd0) ? $signed(MW'(w_dmag[DM_W-1:LO_W]))
                                    : $signed(MW'(w_dmag[LO_W-1:0]));
                m_b = $signed(MW'(w_umag));
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign w_mul = m_a * m_b;

    assign w_numa = r_mag[r_i] << ((r_which == W_NRM) ? NRM_FRAC : TAN_FRAC);
    assign w_num  = w_numa + NUM_W'(r_len >> 1);
    assign w_rnd  = (r_acc + (ACC_W'(1) <<< (LO_W - 1))) >>> LO_W;
    assign w_sm   = w_rnd[34:0];
    assign w_neg  = r_det[DET_W-1] ^ r_unit[r_i][QUO_W-1];

    always_comb begin
        if (w_neg) begin
            w_sat = (w_sm >= 35'h0_8000_0000) ? 32'h8000_0000 : AX_W'(-w_sm);
        end else begin
            w_sat = (w_sm > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : w_sm[AX_W-1:0];
        end
    end

    assign sq_start    = (r_state == S_SQRT) && (r_k == 2'd0);
    assign dv_start    = (r_state == S_DIV) && (r_k == 2'd0) && (r_len != '0);
    assign o_job_ready = r_state == S_IDLE;
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || i_ready);

    ttf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (r_acc[SQ_IN_W-1:0]),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    ttf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dv_start),
        .i_num   (w_num),
        .i_den   (r_len),
        .o_done  (dv_done),
        .o_quo   (dv_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_k     <= '0;
            r_which <= W_NRM;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= S_DET;
                        r_k     <= '0;
                    end
                end
                S_DET: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd2) begin
                        r_state <= S_NSH;
                    end
                end
                S_NSH: begin
                    if (!w_nsh_big) begin
                        r_state <= S_CROSS;
                        r_i     <= '0;
                        r_k     <= '0;
                        r_which <= W_NRM;
                    end
                end
                S_CROSS, S_TB: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd2) begin
                        r_k <= '0;
                        r_i <= w_last_i ? 2'd0 : r_i + 2'd1;
                        if (w_last_i) begin
                            r_state <= S_ULD;
                        end
                    end
                end
                S_ULD: begin
                    r_state <= S_USH;
                end
                S_USH: begin
                    if (!w_ush_big) begin
                        r_state <= S_USQ;
                        r_i     <= '0;
                        r_k     <= '0;
                    end
                end
                S_USQ: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd1) begin
                        r_k <= '0;
                        r_i <= w_last_i ? 2'd0 : r_i + 2'd1;
                        if (w_last_i) begin
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (r_k == 2'd0) begin
                        r_k <= 2'd1;
                    end else if (sq_done) begin
                        r_state <= S_DIV;
                        r_k     <= '0;
                        r_i     <= '0;
                    end
                end
                S_DIV: begin
                    if (r_k == 2'd0 && r_len != '0) begin
                        r_k <= 2'd1;
                    end else if (r_k == 2'd0 || dv_done) begin
                        r_k <= '0;
                        r_i <= w_last_i ? 2'd0 : r_i + 2'd1;
                        if (w_last_i) begin
                            r_state <= S_UEND;
                        end
                    end
                end
                S_UEND: begin
                    r_i <= '0;
                    r_k <= '0;
                    if (r_which == W_NRM) begin
                        r_state <= (r_det == '0) ? S_DONE : S_TB;
                        r_which <= W_TAN;
                    end else begin
                        r_state <= S_SCL;
                    end
                end
                S_SCL: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_k <= '0;
                        r_i <= w_last_i ? 2'd0 : r_i + 2'd1;
                        if (w_last_i) begin
                            r_state <= (r_which == W_TAN) ? S_TB : S_DONE;
                            r_which <= W_BIT;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul[ACC_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                r_e1[0] <= i_job.e1x;
                r_e1[1] <= i_job.e1y;
                r_e1[2] <= i_job.e1z;
                r_e2[0] <= i_job.e2x;
                r_e2[1] <= i_job.e2y;
                r_e2[2] <= i_job.e2z;
                r_t1    <= i_job.t1;
                r_b1    <= i_job.b1;
                r_t2    <= i_job.t2;
                r_b2    <= i_job.b2;
            end
            S_DET: begin
                if (r_k == 2'd1) begin
                    r_acc <= r_prod;
                end
                if (r_k == 2'd2) begin
                    r_det <= w_diff[DET_W-1:0];
                    for (int n = 0; n < 3; n++) begin
                        r_na[n] <= emag(r_e1[n]);
                        r_nb[n] <= emag(r_e2[n]);
                    end
                end
            end
            S_NSH: begin
                if (w_nsh_big) begin
                    for (int n = 0; n < 3; n++) begin
                        r_na[n] <= r_na[n] >> 1;
                        r_nb[n] <= r_nb[n] >> 1;
                    end
                end
            end
            S_CROSS, S_TB: begin
                if (r_k == 2'd1) begin
                    r_acc <= r_prod;
                end
                if (r_k == 2'd2) begin
                    r_vec[r_i] <= w_diff[VEC_W-1:0];
                end
            end
            S_ULD: begin
                for (int n = 0; n < 3; n++) begin
                    r_mag[n] <= vmag(r_vec[n]);
                end
            end
            S_USH: begin
                if (w_ush_big) begin
                    for (int n = 0; n < 3; n++) begin
                        r_mag[n] <= r_mag[n] >> 1;
                    end
                end
            end
            S_USQ: begin
                if (r_k == 2'd1) begin
                    r_acc <= ((r_i == 2'd0) ? '0 : r_acc) + r_prod;
                end
            end
            S_SQRT: begin
                if (sq_done) begin
                    r_len <= sq_root;
                end
            end
            S_DIV: begin
                if (r_k == 2'd0 && r_len == '0) begin
                    r_unit[r_i] <= '0;
                end else if (r_k == 2'd1 && dv_done) begin
                    r_unit[r_i] <= r_vec[r_i][VEC_W-1] ? -$signed(dv_quo) : $signed(dv_quo);
                end
            end
            S_UEND: begin
                if (r_which == W_NRM) begin
                    for (int n = 0; n < 3; n++) begin
                        r_nrm[n] <= r_unit[n][NRM_W-1:0];
                    end
                    r_deg <= r_det == '0;
                    r_tan[0] <= AXIS_ONE;
                    r_tan[1] <= '0;
                    r_tan[2] <= '0;
                    r_bit[0] <= '0;
                    r_bit[1] <= AXIS_ONE;
                    r_bit[2] <= '0;
                end
            end
            S_SCL: begin
                if (r_k == 2'd1) begin
                    r_acc <= r_prod;
                end
                if (r_k == 2'd2) begin
                    r_acc <= r_acc + (r_prod >>> LO_W);
                end
                if (r_k == 2'd3) begin
                    if (r_which == W_TAN) begin
                        r_tan[r_i] <= w_sat;
                    end else begin
                        r_bit[r_i] <= w_sat;
                    end
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {r_nrm[2], r_nrm[1], r_nrm[0], r_bit[2], r_bit[1], r_bit[0],
                           r_tan[2], r_tan[1], r_tan[0]};
            r_out_deg  <= r_deg;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_deg   = r_out_deg;

`ifndef SYNTHESIS
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid && o_job_ready |=> r_state == S_DET)
        else $error("job taken without starting");
    a_sqrt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> r_state == S_SQRT)
        else $error("square root finished outside its step");
    a_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_done |-> r_state == S_DIV && r_k == 2'd1)
        else $error("divide finished outside its step");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> !r_out_valid || i_ready)
        else $error("output overwritten while held");
`endif

endmodule

// ===== hw/rtl/triangle_tangent_frame_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_frame_core
// per-triangle tangent frame: unit face normal and area-scaled tangent basis
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser
// s_axis   in   pos_x pos_y pos_z tex_u tex_v (144 b)   -
// m_axis   out  tan xyz, bitan xyz, normal xyz (240 b)  degenerate
//
// vertices 0 and 1 of a triangle are taken whenever they are offered
// the third vertex is taken whenever the job queue has room
// a triangle's time in the datapath is set by the serial divider (three per
// unit vector), square root (one per unit vector) and the normalizing shifts,
// and is shorter when degenerate
// synchronous active-low reset clears the vertex count, queue and sequencer
// ----------------------------------------------------------------------------
module triangle_tangent_frame_core
    import ttf_pkg::*;
#(
    parameter int QUEUE_DEPTH = TTF_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // tangent_x/y/z, bitangent_x/y/z, normal_x/y/z
    output logic [OUT_W-1:0] o_m_axis_tdata,
    // degenerate
    output logic             o_m_axis_tuser
);

    logic fq_valid, fq_ready;
    logic qb_valid, qb_ready;
    t_job fq_job, qb_job;

    ttf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .o_job_valid (fq_valid),
        .i_job_ready (fq_ready),
        .o_job       (fq_job)
    );

    ttf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_job   (fq_job),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_job    (qb_job)
    );

    ttf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (qb_valid),
        .o_job_ready (qb_ready),
        .i_job       (qb_job),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (o_m_axis_tdata),
        .o_deg       (o_m_axis_tuser)
    );

endmodule

// ===== sim/tb_triangle_tangent_frame_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_tangent_frame_core
// self-checking bench for the per-triangle tangent frame core
// ----------------------------------------------------------------------------
// vertices stream in, a local model computes each triangle's normal, tangent
// and bitangent, and every output transfer is matched against the oldest
// predicted frame; a directed table comes first, then random triangles under
// several sender and receiver idling patterns
// ----------------------------------------------------------------------------
module tb_triangle_tangent_frame_core;
    import ttf_pkg::*;

    localparam int  N_RANDOM    = 1450;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  DRAIN_WAIT  = 2000;
    localparam int  N_ROWS      = 18;

    typedef logic [OUT_W:0] frame_t;
    typedef longint vec3_t[3];

    typedef struct {
        logic [IN_W-1:0] vtx;
        bit              typed;
        frame_t          frame;
    } row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [OUT_W-1:0]  o_m_axis_tdata;
    logic              o_m_axis_tuser;

    triangle_tangent_frame_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // model state
    longint  held_pos[6];
    longint  held_uv[4];
    int      phase_cnt;

    frame_t  frame_q[$];
    int      n_errors;
    longint  cycle_cnt;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      cur_typed;
    frame_t  cur_frame;
    row_t    rows[N_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [IN_W-1:0] pack_vertex(input logic [31:0] x, input logic [31:0] y,
                                                    input logic [31:0] z, input logic [23:0] u,
                                                    input logic [23:0] v);
        return {v, u, z, y, x};
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic int shift_to_fit(input longint unsigned mx);
        int s;
        s = 0;
        while (s < 63 && (mx >> s) >= (64'd1 << 30)) s++;
        return s;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void normalize(input vec3_t v, input int frac, output vec3_t q);
        longint unsigned a[3];
        longint unsigned mx, sum, len, r;
        int s;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = magnitude(v[i]);
            if (a[i] > mx) mx = a[i];
        end
        s = shift_to_fit(mx);
        for (int i = 0; i < 3; i++) begin
            a[i] = a[i] >> s;
            sum += a[i] * a[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            if (len == 0) begin
                q[i] = 0;
            end else begin
                r = ((a[i] << frac) + (len >> 1)) / len;
                q[i] = (v[i] < 0) ? -longint'(r) : longint'(r);
            end
        end
    endfunction

    function automatic logic [31:0] scale_axis_comp(input longint det, input longint u);
        longint unsigned d, m, hi, lo, q;
        bit neg;
        d = magnitude(det);
        m = magnitude(u);
        hi = d >> 23;
        lo = d & ((64'd1 << 23) - 1);
        q = hi * m + ((lo * m) >> 23);
        q = (q + (64'd1 << 22)) >> 23;
        neg = (det < 0) != (u < 0);
        if (neg) return (q >= (64'd1 << 31)) ? 32'h8000_0000 : 32'(-q);
        return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
    endfunction

    // advances the vertex count; returns 1 with the frame on a triangle's last vertex
    function automatic bit predict_frame(input logic [IN_W-1:0] vtx, output frame_t frame);
        longint p[3], e1[3], e2[3], a[3], b[3];
        vec3_t cr, nq, tv, bv, tu, bu;
        longint tu_in, tv_in, t1, b1, t2, b2, det;
        longint unsigned mx;
        int s;
        for (int i = 0; i < 3; i++) p[i] = longint'($signed(vtx[32*i +: 32]));
        tu_in = longint'($signed(vtx[96 +: 24]));
        tv_in = longint'($signed(vtx[120 +: 24]));
        frame = '0;
        if (phase_cnt < 2) begin
            for (int i = 0; i < 3; i++) held_pos[phase_cnt*3 + i] = p[i];
            held_uv[phase_cnt*2]     = tu_in;
            held_uv[phase_cnt*2 + 1] = tv_in;
            phase_cnt++;
            return 0;
        end
        phase_cnt = 0;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            e1[i] = held_pos[3 + i] - held_pos[i];
            e2[i] = p[i] - held_pos[i];
            if (magnitude(e1[i]) > mx) mx = magnitude(e1[i]);
            if (magnitude(e2[i]) > mx) mx = magnitude(e2[i]);
        end
        t1 = held_uv[2] - held_uv[0];
        b1 = held_uv[3] - held_uv[1];
        t2 = tu_in - held_uv[0];
        b2 = tv_in - held_uv[1];
        det = t1 * b2 - b1 * t2;
        s = shift_to_fit(mx);
        for (int i = 0; i < 3; i++) begin
            a[i] = (e1[i] < 0) ? -longint'(magnitude(e1[i]) >> s) : longint'(magnitude(e1[i]) >> s);
            b[i] = (e2[i] < 0) ? -longint'(magnitude(e2[i]) >> s) : longint'(magnitude(e2[i]) >> s);
        end
        cr[0] = a[1] * b[2] - a[2] * b[1];
        cr[1] = a[2] * b[0] - a[0] * b[2];
        cr[2] = a[0] * b[1] - a[1] * b[0];
        normalize(cr, NRM_FRAC, nq);
        if (det != 0) begin
            for (int i = 0; i < 3; i++) begin
                tv[i] = b2 * e1[i] - b1 * e2[i];
                bv[i] = t1 * e2[i] - t2 * e1[i];
            end
            normalize(tv, TAN_FRAC, tu);
            normalize(bv, TAN_FRAC, bu);
            for (int i = 0; i < 3; i++) begin
                frame[32*i +: 32]      = scale_axis_comp(det, tu[i]);
                frame[96 + 32*i +: 32] = scale_axis_comp(det, bu[i]);
            end
        end else begin
            frame[31:0]    = AXIS_ONE;
            frame[159:128] = AXIS_ONE;
            frame[OUT_W]   = 1'b1;
        end
        for (int i = 0; i < 3; i++) frame[192 + 16*i +: 16] = nq[i][15:0];
        return 1;
    endfunction

    // input side: every accepted vertex feeds the model
    always @(posedge i_clk) begin
        frame_t f;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            if (predict_frame(i_s_axis_tdata, f)) frame_q = {frame_q, cur_typed ? cur_frame : f};
        end
    end

    // output side: receiver stalls and frame checking
    always @(posedge i_clk) begin
        frame_t exp_f, got_f;
        string  names[10];
        names = '{"tangent_x", "tangent_y", "tangent_z", "bitangent_x", "bitangent_y",
                  "bitangent_z", "normal_x", "normal_y", "normal_z", "degenerate"};
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("triangle_tangent_frame_core verification failed");
            $finish;
        end
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_f = {o_m_axis_tuser, o_m_axis_tdata};
            if (frame_q.size() == 0) begin
                $error("unexpected output transfer %h", got_f);
                n_errors++;
            end else begin
                exp_f = frame_q.pop_front();
                for (int i = 0; i < 6; i++) begin
                    if (exp_f[32*i +: 32] !== got_f[32*i +: 32]) begin
                        $error("%s: expected %h, got %h", names[i],
                               exp_f[32*i +: 32], got_f[32*i +: 32]);
                        n_errors++;
                    end
                end
                for (int i = 0; i < 3; i++) begin
                    if (exp_f[192 + 16*i +: 16] !== got_f[192 + 16*i +: 16]) begin
                        $error("%s: expected %h, got %h", names[6 + i],
                               exp_f[192 + 16*i +: 16], got_f[192 + 16*i +: 16]);
                        n_errors++;
                    end
                end
                if (exp_f[OUT_W] !== got_f[OUT_W]) begin
                    $error("%s: expected %b, got %b", names[9], exp_f[OUT_W], got_f[OUT_W]);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_vertex(input logic [IN_W-1:0] vtx, input bit typed, input frame_t f);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= vtx;
        cur_typed       <= typed;
        cur_frame       <= f;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_random_triangle();
        logic [31:0] px[3], py[3], pz[3];
        logic [23:0] u[3], v[3];
        int kind;
        kind = $urandom_range(9);
        for (int k = 0; k < 3; k++) begin
            if (kind < 3) begin
                px[k] = $urandom; py[k] = $urandom; pz[k] = $urandom;
                u[k] = $urandom; v[k] = $urandom;
            end else begin
                px[k] = 32'($signed($urandom_range(2097151)) - 1048576);
                py[k] = 32'($signed($urandom_range(2097151)) - 1048576);
                pz[k] = 32'($signed($urandom_range(2097151)) - 1048576);
                u[k]  = 24'($signed($urandom_range(524287)) - 262144);
                v[k]  = 24'($signed($urandom_range(524287)) - 262144);
            end
        end
        if (kind == 8) begin
            u[1] = u[0]; u[2] = u[0]; v[1] = v[0]; v[2] = v[0];
        end
        if (kind == 9) begin
            px[2] = px[1] + px[1] - px[0];
            py[2] = py[1] + py[1] - py[0];
            pz[2] = pz[1] + pz[1] - pz[0];
        end
        for (int k = 0; k < 3; k++) send_vertex(pack_vertex(px[k], py[k], pz[k], u[k], v[k]), 0, '0);
    endtask

    initial begin
        int n_sent, waited;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        cur_typed       = 1'b0;
        cur_frame       = '0;
        n_errors        = 0;
        cycle_cnt       = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        phase_cnt       = 0;
        for (int i = 0; i < 6; i++) held_pos[i] = 0;
        for (int i = 0; i < 4; i++) held_uv[i] = 0;

        // all-zero triangle: degenerate default axes, zero normal
        rows[0]  = '{pack_vertex(0, 0, 0, 0, 0), 0, '0};
        rows[1]  = '{pack_vertex(0, 0, 0, 0, 0), 0, '0};
        rows[2]  = '{pack_vertex(0, 0, 0, 0, 0), 1,
                     {1'b1, 48'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000}};
        // axis-aligned unit triangle
        rows[3]  = '{pack_vertex(0, 0, 0, 0, 0), 0, '0};
        rows[4]  = '{pack_vertex(32'h0001_0000, 0, 0, 24'h01_0000, 0), 0, '0};
        rows[5]  = '{pack_vertex(0, 32'h0001_0000, 0, 0, 24'h01_0000), 0, '0};
        // full-range positions and texture coordinates
        rows[6]  = '{pack_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                 24'h80_0000, 24'h7F_FFFF), 0, '0};
        rows[7]  = '{pack_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                 24'h7F_FFFF, 24'h80_0000), 0, '0};
        rows[8]  = '{pack_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                 24'h80_0000, 24'h80_0000), 0, '0};
        // collinear points: zero normal
        rows[9]  = '{pack_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0), 0, '0};
        rows[10] = '{pack_vertex(32'h0002_0000, 32'h0004_0000, 32'h0006_0000,
                                 24'h00_4000, 24'h01_0000), 0, '0};
        rows[11] = '{pack_vertex(32'h0003_0000, 32'h0006_0000, 32'h0009_0000,
                                 24'h02_0000, 24'h00_1000), 0, '0};
        // coincident positions with a nonzero determinant: zero tangent frame
        rows[12] = '{pack_vertex(32'h1234_5678, 32'hFEDC_BA98, 32'h0, 24'h0, 24'h0), 0, '0};
        rows[13] = '{pack_vertex(32'h1234_5678, 32'hFEDC_BA98, 32'h0, 24'h01_0000, 24'h0), 0, '0};
        rows[14] = '{pack_vertex(32'h1234_5678, 32'hFEDC_BA98, 32'h0, 24'h0, 24'h01_0000), 0, '0};
        // huge determinant: saturating tangent
        rows[15] = '{pack_vertex(32'h0, 32'h0, 32'h0, 24'h80_0000, 24'h80_0000), 0, '0};
        rows[16] = '{pack_vertex(32'h4000_0000, 32'h0, 32'h0, 24'h7F_FFFF, 24'h80_0000), 0, '0};
        rows[17] = '{pack_vertex(32'h0, 32'hC000_0000, 32'h0, 24'h80_0000, 24'h7F_FFFF), 0, '0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) send_vertex(rows[r].vtx, rows[r].typed, rows[r].frame);

        n_sent = 0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                3: begin send_idle_pct = 17; recv_stall_pct = 17; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            while (n_sent < (N_RANDOM * (ph + 1)) / 5) begin
                send_random_triangle();
                n_sent += 3;
            end
        end
        i_s_axis_tvalid <= 1'b0;

        waited = 0;
        while (frame_q.size() != 0 && waited < CYCLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (n_errors == 0 && frame_q.size() == 0) begin
            $display("triangle_tangent_frame_core verification clean");
        end else begin
            $display("triangle_tangent_frame_core verification failed");
        end
        $finish;
    end

endmodule
